### hdl/assert_macros.svh
// assert_macros.svh: assertion macros for the dispatcher checkers.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define FJD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same-cycle implication
`define FJD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    `FJD_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// next-cycle implication
`define FJD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    `FJD_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

### hdl/fjd_pkg.sv
// fjd_pkg: job record type, status codes and queue control structs for the
// first-come-first-served dispatcher. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fjd_pkg;

    localparam int ARRIVAL_W = 32;
    localparam int TASK_W    = 6;
    localparam int RUN_W     = 16;
    localparam int INST_W    = 16;

    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_DROPPED    = 2'd1;
    localparam logic [1:0] ST_DISPATCHED = 2'd2;
    localparam logic [1:0] ST_IDLE       = 2'd3;

    localparam logic CMD_PUSH     = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [TASK_W-1:0]    task_id;
        logic [RUN_W-1:0]     run;
    } job_t;

    typedef struct packed {
        logic push;
        logic find;
        logic remove;
    } q_ctrl_t;

    typedef struct packed {
        logic done;
        job_t best;
    } q_stat_t;

endpackage

`default_nettype wire

### hdl/fjd_job_queue.sv
// fjd_job_queue: job store in push order; a sequential scan finds the job
// with least {arrival, task_id}, a shift pass removes it. Depends on fjd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fjd_job_queue #(
    parameter int JOBS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire fjd_pkg::q_ctrl_t         ctrl,
    input  wire fjd_pkg::job_t            push_job,
    output fjd_pkg::q_stat_t              stat,
    output logic [$clog2(JOBS+1)-1:0]     job_count
);

    localparam int AW = $clog2(JOBS);
    localparam int CW = $clog2(JOBS + 1);

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_SCAN,
        Q_SHIFT
    } q_state_t;

    q_state_t          q_state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     issue_reg;
    logic              pend_vld_reg;
    logic [AW-1:0]     pend_idx_reg;
    fjd_pkg::job_t     best_reg;
    logic [AW-1:0]     best_pos_reg;
    logic              done_reg;
    fjd_pkg::job_t     rd_data_reg;

    fjd_pkg::job_t     heap [JOBS];

    logic              issuing;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    fjd_pkg::job_t     wr_data;
    logic              rd_less;

    assign issuing = (q_state_reg != Q_IDLE) && (issue_reg < count_reg);
    assign rd_addr = issue_reg[AW-1:0];
    assign rd_less = {rd_data_reg.arrival, rd_data_reg.task_id}
                   < {best_reg.arrival, best_reg.task_id};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = push_job;
        if (ctrl.push)
        begin
            wr_en = 1'b1;
        end
        else if (q_state_reg == Q_SHIFT && pend_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg - AW'(1);
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap[wr_addr] <= wr_data;
        end
        rd_data_reg <= heap[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_state_reg  <= Q_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            best_pos_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            pend_vld_reg <= issuing;
            pend_idx_reg <= rd_addr;
            if (issuing)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            case (q_state_reg)
                Q_IDLE:
                begin
                    if (ctrl.push)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    else if (ctrl.find)
                    begin
                        issue_reg   <= '0;
                        q_state_reg <= Q_SCAN;
                    end
                    else if (ctrl.remove)
                    begin
                        issue_reg   <= CW'(best_pos_reg) + CW'(1);
                        q_state_reg <= Q_SHIFT;
                    end
                end
                Q_SCAN:
                begin
                    if (pend_vld_reg && (pend_idx_reg == '0 || rd_less))
                    begin
                        best_reg     <= rd_data_reg;
                        best_pos_reg <= pend_idx_reg;
                    end
                    if (!issuing && !pend_vld_reg)
                    begin
                        done_reg    <= 1'b1;
                        q_state_reg <= Q_IDLE;
                    end
                end
                Q_SHIFT:
                begin
                    if (!issuing && !pend_vld_reg)
                    begin
                        count_reg   <= count_reg - CW'(1);
                        done_reg    <= 1'b1;
                        q_state_reg <= Q_IDLE;
                    end
                end
                default:
                begin
                    q_state_reg <= Q_IDLE;
                end
            endcase
        end
    end

    assign stat.done = done_reg;
    assign stat.best = best_reg;
    assign job_count = count_reg;

endmodule

`default_nettype wire

### hdl/fcfs_job_dispatcher.sv
// fcfs_job_dispatcher: top level of the first-come-first-served dispatcher;
// sequencer, clock, idle and per-task counters. Depends on fjd_pkg, fjd_job_queue.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_ready | command, arrival_time, task_id, run_time
//   out     | out_valid/out_ready | status, event_time, out_task, instance_res, queue_empty
//
// Push, drop or dispatch on an empty queue: the result is registered, then moves into
// the output register once that is free. Dispatch with queued jobs: a scan of the job
// store (one read per cycle) finds the earliest job or an idle interval. A dispatch
// then reads and updates the instance counter memory and runs a shift pass over the
// entries behind the removed job before its result moves to the output register.
// No clearing pass after reset; instance counters use per-entry valid bits.
// in_ready is low while an item is in work; a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module fcfs_job_dispatcher #(
    parameter int JOBS  = 64,
    parameter int TASKS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [31:0] arrival_time,
    input  wire logic [5:0]  task_id,
    input  wire logic [15:0] run_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      event_time,
    output logic [5:0]       out_task,
    output logic [15:0]      instance_res,
    output logic             queue_empty
);

    localparam int CW  = $clog2(JOBS + 1);
    localparam int TSW = (TASKS > 1) ? $clog2(TASKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_CNT_RD,
        S_CNT_UPD,
        S_REMOVE,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [31:0]            clock_reg;
    logic [15:0]            idle_reg;
    logic [5:0]             mod_reg;
    logic [TASKS-1:0]       ti_valid_reg;
    logic [15:0]            ti_rd_reg;
    logic                   ti_vld_rd_reg;
    logic [1:0]             res_status_reg;
    logic [31:0]            res_time_reg;
    logic [5:0]             res_task_reg;
    logic [15:0]            res_inst_reg;
    logic                   res_empty_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [31:0]            out_time_reg;
    logic [5:0]             out_task_reg;
    logic [15:0]            out_inst_reg;
    logic                   out_empty_reg;

    logic [15:0]            ti_mem [TASKS];

    fjd_pkg::q_ctrl_t       q_ctrl;
    fjd_pkg::q_stat_t       q_stat;
    fjd_pkg::job_t          push_job;
    logic [CW-1:0]          job_count;

    logic                   in_fire;
    logic                   q_full;
    logic [TSW-1:0]         slot;
    logic [15:0]            cnt;
    logic [15:0]            inst_next;
    logic                   ti_we;
    logic [32:0]            clock_sum;

    function automatic logic [TSW-1:0] task_slot(input logic [5:0] t);
        logic [TSW-1:0] s;
        s = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (t == 6'(i))
            begin
                s = TSW'(i % TASKS);
            end
        end
        return s;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign q_full    = (job_count == CW'(JOBS));
    assign slot      = task_slot(mod_reg);
    assign cnt       = ti_vld_rd_reg ? ti_rd_reg : 16'd0;
    assign inst_next = (cnt == 16'hFFFF) ? 16'hFFFF : cnt + 16'd1;
    assign ti_we     = (state_reg == S_CNT_UPD);
    assign clock_sum = {1'b0, clock_reg} + 33'(q_stat.best.run);

    assign push_job.arrival = arrival_time;
    assign push_job.task_id = task_id;
    assign push_job.run     = run_time;

    assign q_ctrl.push   = in_fire && (command == fjd_pkg::CMD_PUSH) && !q_full;
    assign q_ctrl.find   = in_fire && (command == fjd_pkg::CMD_DISPATCH)
                         && (job_count != '0);
    assign q_ctrl.remove = ti_we;

    fjd_job_queue #(
        .JOBS (JOBS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_job  (push_job),
        .stat      (q_stat),
        .job_count (job_count)
    );

    always_ff @(posedge clk)
    begin
        if (ti_we)
        begin
            ti_mem[slot] <= inst_next;
        end
        ti_rd_reg <= ti_mem[slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clock_reg     <= '0;
            idle_reg      <= 16'd1;
            ti_valid_reg  <= '0;
            ti_vld_rd_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_time_reg <= clock_reg;
                        res_task_reg <= '0;
                        res_inst_reg <= '0;
                        if (command == fjd_pkg::CMD_PUSH)
                        begin
                            res_status_reg <= q_full ? fjd_pkg::ST_DROPPED
                                                     : fjd_pkg::ST_ACCEPTED;
                            res_empty_reg  <= 1'b0;
                            state_reg      <= S_FIN;
                        end
                        else if (job_count == '0)
                        begin
                            res_status_reg <= fjd_pkg::ST_IDLE;
                            res_inst_reg   <= idle_reg;
                            res_empty_reg  <= 1'b1;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_FIND:
                begin
                    if (q_stat.done)
                    begin
                        if (q_stat.best.arrival <= clock_reg)
                        begin
                            mod_reg   <= q_stat.best.task_id;
                            state_reg <= S_CNT_RD;
                        end
                        else
                        begin
                            res_status_reg <= fjd_pkg::ST_IDLE;
                            res_inst_reg   <= idle_reg;
                            res_empty_reg  <= 1'b0;
                            clock_reg      <= q_stat.best.arrival;
                            if (idle_reg != 16'hFFFF)
                            begin
                                idle_reg <= idle_reg + 16'd1;
                            end
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_CNT_RD:
                begin
                    ti_vld_rd_reg <= ti_valid_reg[slot];
                    state_reg     <= S_CNT_UPD;
                end
                S_CNT_UPD:
                begin
                    ti_valid_reg[slot] <= 1'b1;
                    res_status_reg     <= fjd_pkg::ST_DISPATCHED;
                    res_task_reg       <= q_stat.best.task_id;
                    res_inst_reg       <= inst_next;
                    clock_reg          <= clock_sum[32] ? 32'hFFFF_FFFF : clock_sum[31:0];
                    state_reg          <= S_REMOVE;
                end
                S_REMOVE:
                begin
                    if (q_stat.done)
                    begin
                        res_empty_reg <= (job_count == '0);
                        state_reg     <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_time_reg   <= res_time_reg;
                        out_task_reg   <= res_task_reg;
                        out_inst_reg   <= res_inst_reg;
                        out_empty_reg  <= res_empty_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign event_time   = out_time_reg;
    assign out_task     = out_task_reg;
    assign instance_res = out_inst_reg;
    assign queue_empty  = out_empty_reg;

endmodule

`default_nettype wire

### hdl/fjd_checker.sv
// fjd_checker: port-level assertions for the dispatcher, bound to the top level.
// Depends on fjd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fjd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        command,
    input wire logic [31:0] arrival_time,
    input wire logic [5:0]  task_id,
    input wire logic [15:0] run_time,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [31:0] event_time,
    input wire logic [5:0]  out_task,
    input wire logic [15:0] instance_res,
    input wire logic        queue_empty
);

    // one item in work at a time
    `FJD_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready, "in_ready high after a transfer")

    // push records carry no task, no instance and a non-empty queue
    `FJD_ASSERT_IMPLY(a_push_record, clk, rst_n, out_valid && (status == fjd_pkg::ST_ACCEPTED || status == fjd_pkg::ST_DROPPED), out_task == 6'd0 && instance_res == 16'd0 && !queue_empty, "bad push record")

    // idle records carry no task and a nonzero idle count
    `FJD_ASSERT_IMPLY(a_idle_record, clk, rst_n, out_valid && status == fjd_pkg::ST_IDLE, out_task == 6'd0 && instance_res != 16'd0, "bad idle record")

    // hold a stalled result
    `FJD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_time) && $stable(status), "stalled result changed")

endmodule

bind fcfs_job_dispatcher fjd_checker u_fjd_checker (.*);

`default_nettype wire
